>>> src/tnl_pkg.sv
// Package for the top-N largest tracker.
// Holds the item structs, table entry layout, command codes and sequencer states.
// Has no dependencies; every other file of the block imports it.
package tnl_pkg;

	typedef struct packed {
		logic        command;
		logic [63:0] key;
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [5:0]  read_index;
	} req_t;

	typedef struct packed {
		logic        inserted;
		logic [6:0]  position;
		logic [6:0]  entry_count;
		logic        read_valid;
		logic [63:0] read_key;
		logic [63:0] read_id_high;
		logic [63:0] read_id_low;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] id_high;
		logic [63:0] id_low;
	} entry_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_CMP,
		ST_SLOT,
		ST_SHIFT,
		ST_PLACE,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} seq_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

>>> src/tnl_mem.sv
// Entry memory of the top-N largest tracker: one write port, one registered read port.
// Depends on tnl_pkg for the entry layout.
module tnl_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  tnl_pkg::entry_t     wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output tnl_pkg::entry_t     rd_data
);
	import tnl_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/tnl_seq.sv
// Sequencer of the top-N largest tracker: binary search, shift and read of the table.
// One key comparator on the memory read data is reused for every probe.
// Depends on tnl_pkg and drives the ports of tnl_mem.
module tnl_seq #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW          = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tnl_pkg::seq_ctrl_t   ctrl,
	input  tnl_pkg::req_t        req,
	output tnl_pkg::seq_stat_t   stat,
	output tnl_pkg::rsp_t        rsp,
	output logic                 mem_wr_en,
	output logic [AW-1:0]        mem_wr_addr,
	output tnl_pkg::entry_t      mem_wr_data,
	output logic                 mem_rd_en,
	output logic [AW-1:0]        mem_rd_addr,
	input  tnl_pkg::entry_t      mem_rd_data
);
	import tnl_pkg::*;

	localparam int UW = ($clog2(TABLE_DEPTH + 1) > 6) ? $clog2(TABLE_DEPTH + 1) : 6;
	localparam int CW = UW + 1;
	localparam logic signed [CW-1:0] ONE       = CW'(1);
	localparam logic signed [CW-1:0] LAST_MOVE = CW'(TABLE_DEPTH - 2);
	localparam logic signed [CW-1:0] DEPTH_S   = CW'(TABLE_DEPTH);
	localparam logic [UW-1:0]        DEPTH_U   = UW'(TABLE_DEPTH);

	state_t state_q, state_d;
	logic [UW-1:0] count_q;
	logic pend_q;
	req_t req_q;
	rsp_t res_q;
	logic signed [CW-1:0] lo_q, hi_q, mid_q, slot_q, k_q;
	logic [AW-1:0] wa_q;

	logic [CW:0] mid_sum;
	logic signed [CW-1:0] mid_c, lo_n, hi_n, count_s, k_init, k_p1;
	logic key_eq, key_lt, key_gt;
	logic rd_hit, shift_go;
	logic [UW-1:0] ridx_u;

	always_comb begin
		count_s = CW'(count_q);
		mid_sum = {lo_q[CW-1], lo_q} + {hi_q[CW-1], hi_q};
		mid_c   = mid_sum[CW:1];
		key_eq  = (mem_rd_data.key == req_q.key);
		key_lt  = (mem_rd_data.key < req_q.key);
		key_gt  = !key_eq && !key_lt;
		lo_n    = key_lt ? lo_q : mid_q + ONE;
		hi_n    = key_lt ? mid_q - ONE : hi_q;
		ridx_u  = UW'(req_q.read_index);
		rd_hit  = (ridx_u < count_q);
		k_init  = ((count_s - ONE) > LAST_MOVE) ? LAST_MOVE : count_s - ONE;
		k_p1    = k_q + ONE;
		shift_go = (k_q >= slot_q);
	end

	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = wa_q;
		mem_wr_data = mem_rd_data;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (req_q.command == CMD_READ) begin
					if (rd_hit) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = AW'(req_q.read_index);
						state_d     = ST_RD_WAIT;
					end else begin
						state_d = ST_DONE;
					end
				end else if (req_q.key == 64'd0) begin
					state_d = ST_DONE;
				end else if (count_q == '0) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = mid_c[AW-1:0];
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				if (key_eq || (lo_n > hi_n)) begin
					state_d = ST_SLOT;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_SLOT: begin
				if (slot_q >= DEPTH_S) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				mem_wr_en = pend_q;
				if (shift_go) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = k_q[AW-1:0];
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q[AW-1:0];
				mem_wr_data = '{key: req_q.key, id_high: req_q.id_high, id_low: req_q.id_low};
				state_d     = ST_DONE;
			end
			ST_RD_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (ctrl.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == ST_SHIFT) && shift_go;
			if ((state_q == ST_PLACE) && (count_q != DEPTH_U)) begin
				count_q <= count_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					req_q <= req;
				end
			end
			ST_START: begin
				res_q  <= '{inserted: 1'b0, position: 7'(TABLE_DEPTH), entry_count: '0,
					read_valid: 1'b0, read_key: '0, read_id_high: '0, read_id_low: '0};
				lo_q   <= '0;
				hi_q   <= count_s - ONE;
				slot_q <= '0;
			end
			ST_PROBE: begin
				mid_q <= mid_c;
			end
			ST_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				if (key_eq) begin
					slot_q <= mid_q;
				end else begin
					slot_q <= (key_gt && !hi_n[CW-1]) ? mid_q + ONE : mid_q;
				end
			end
			ST_SLOT: begin
				k_q <= k_init;
			end
			ST_SHIFT: begin
				k_q  <= k_q - ONE;
				wa_q <= k_p1[AW-1:0];
			end
			ST_PLACE: begin
				res_q.inserted <= 1'b1;
				res_q.position <= 7'(slot_q);
			end
			ST_RD_WAIT: begin
				res_q.read_valid   <= 1'b1;
				res_q.read_key     <= mem_rd_data.key;
				res_q.read_id_high <= mem_rd_data.id_high;
				res_q.read_id_low  <= mem_rd_data.id_low;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp             = res_q;
		rsp.entry_count = 7'(count_q);
		stat.idle       = (state_q == ST_IDLE);
		stat.done       = (state_q == ST_DONE) && ctrl.out_free;
	end

endmodule

>>> src/top_n_largest_tracker.sv
// Top level of the top-N largest tracker: handshakes, output register and the entry memory.
// Instantiates tnl_seq and tnl_mem and depends on tnl_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req (tnl_pkg::req_t)
//   rsp     | out       | rsp_valid, rsp_stall | rsp (tnl_pkg::rsp_t)
//
// A read whose read_index is not below the entry count and an insert with a zero key
// finish without a memory access; an insert into an empty table writes without a probe.
// Other inserts make up to log2(TABLE_DEPTH)+1 binary search probes, then move the entries
// from the slot on down one place, each probe and each move using the single memory
// read port; a key dropped from a full table makes the probes but no moves.
// The table is empty after reset, and the memory needs no clearing pass.
// req_stall is high from acceptance until the result enters the output register.
// The next item is accepted while a result waits in the output register.
module top_n_largest_tracker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tnl_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tnl_pkg::rsp_t  rsp
);
	import tnl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	seq_ctrl_t ctrl;
	seq_stat_t stat;
	rsp_t seq_rsp, rsp_q;
	logic rsp_valid_q;
	logic mem_wr_en, mem_rd_en;
	logic [AW-1:0] mem_wr_addr, mem_rd_addr;
	entry_t mem_wr_data, mem_rd_data;

	always_comb begin
		ctrl.start    = req_valid && stat.idle;
		ctrl.out_free = !rsp_valid_q || !rsp_stall;
	end

	assign req_stall = !stat.idle;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= seq_rsp;
		end
	end

	tnl_seq #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.req(req),
		.stat(stat),
		.rsp(seq_rsp),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	tnl_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

endmodule

>>> src/tnl_chk.sv
// Port checker of the top-N largest tracker and its bind to the top level.
// Depends on tnl_pkg; sees only the ports of top_n_largest_tracker.
module tnl_chk #(
	parameter int TABLE_DEPTH = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input tnl_pkg::rsp_t  rsp
);
	import tnl_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled result item changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block did not go busy after accepting an item");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_valid |->
			!rsp.inserted && (rsp.position == 7'(TABLE_DEPTH)))
		else $error("read result carries insert fields");

endmodule

bind top_n_largest_tracker tnl_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_tnl_chk (.*);

>>> sim/tnl_rank_checker.sv
// Checker for the top-N largest tracker: keeps its own sorted table, predicts every result
// from the accepted request items and compares the results that the block hands out.
// Depends on tnl_pkg for the item structs and command codes.
module tnl_rank_checker #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  tnl_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  tnl_pkg::rsp_t rsp,
	output int            fail_count,
	output int            rsp_backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	import tnl_pkg::*;

	logic [63:0] rank_key [DEPTH];
	logic [63:0] rank_idh [DEPTH];
	logic [63:0] rank_idl [DEPTH];
	int          rank_count = 0;
	int          errors = 0;
	rsp_t        table_rsp_q [$];

	function automatic int locate_slot(logic [63:0] k);
		int lo = 0;
		int hi = rank_count - 1;
		int mid = 0;
		if (rank_count == 0) begin
			return 0;
		end
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (rank_key[mid] == k) begin
				return mid;
			end
			if (rank_key[mid] < k) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		if (rank_key[mid] > k && hi >= 0) begin
			mid++;
		end
		return mid;
	endfunction

	function automatic rsp_t rank_table_step(req_t r);
		rsp_t o;
		int   slot;
		int   last;
		o = '0;
		o.position = 7'(DEPTH);
		if (r.command == CMD_INSERT) begin
			if (r.key != 64'd0) begin
				slot = locate_slot(r.key);
				if (slot < DEPTH) begin
					last = rank_count - 1;
					if (last > DEPTH - 2) begin
						last = DEPTH - 2;
					end
					for (int j = last; j >= slot; j--) begin
						rank_key[j + 1] = rank_key[j];
						rank_idh[j + 1] = rank_idh[j];
						rank_idl[j + 1] = rank_idl[j];
					end
					rank_key[slot] = r.key;
					rank_idh[slot] = r.id_high;
					rank_idl[slot] = r.id_low;
					if (rank_count < DEPTH) begin
						rank_count++;
					end
					o.inserted = 1'b1;
					o.position = 7'(slot);
				end
			end
		end else if (int'(r.read_index) < rank_count) begin
			o.read_valid   = 1'b1;
			o.read_key     = rank_key[r.read_index];
			o.read_id_high = rank_idh[r.read_index];
			o.read_id_low  = rank_idl[r.read_index];
		end
		o.entry_count = 7'(rank_count);
		return o;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t ns: %s expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (table_rsp_q.size() == 0) begin
					errors++;
					$display("%0t ns: result expected none, actual %h", $time, rsp);
				end else begin
					want = table_rsp_q.pop_front();
					check_field("inserted", 64'(want.inserted), 64'(rsp.inserted));
					check_field("position", 64'(want.position), 64'(rsp.position));
					check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
					check_field("read_valid", 64'(want.read_valid), 64'(rsp.read_valid));
					check_field("read_key", want.read_key, rsp.read_key);
					check_field("read_id_high", want.read_id_high, rsp.read_id_high);
					check_field("read_id_low", want.read_id_low, rsp.read_id_low);
				end
			end
			if (req_valid && !req_stall) begin
				table_rsp_q.push_back(rank_table_step(req));
			end
		end
		fail_count  <= errors;
		rsp_backlog <= table_rsp_q.size();
	end

endmodule

>>> sim/tb_top.sv
// Testbench top for the top-N largest tracker: clock, reset, request stimulus and stalls.
// Instantiates top_n_largest_tracker and tnl_rank_checker; depends on tnl_pkg.
// Gives the verdict from the checker's failure count and outstanding results.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tnl_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int DEPTH          = 64;
	localparam int PHASE_ITEMS    = 410;
	localparam int WATCHDOG_LIMIT = 4000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;
	int    fail_count;
	int    rsp_backlog;
	int    tx_idle_pct = 11;
	int    rx_idle_pct = 49;
	int    quiet_cycles = 0;
	int    n_insert = 0;
	int    n_zero = 0;
	int    n_read = 0;
	logic [63:0] recent_keys [$];

	always #(CLK_PERIOD / 2) clk = ~clk;

	top_n_largest_tracker #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	tnl_rank_checker #(.DEPTH(DEPTH)) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.rsp_backlog (rsp_backlog)
	);

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("top_n_largest_tracker: mismatch");
		$finish;
	end

	function automatic req_t make_req(logic cmd, logic [63:0] k, logic [63:0] idh,
			logic [63:0] idl, logic [5:0] idx);
		req_t r;
		r.command    = cmd;
		r.key        = k;
		r.id_high    = idh;
		r.id_low     = idl;
		r.read_index = idx;
		return r;
	endfunction

	function automatic logic [63:0] random_key();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5) begin
			return 64'd0;
		end else if (pick < 12) begin
			case ($urandom_range(3))
				0: return 64'd1;
				1: return '1;
				2: return {{63{1'b1}}, 1'b0};
				default: return 64'h8000_0000_0000_0000;
			endcase
		end else if (pick < 30 && recent_keys.size() != 0) begin
			return recent_keys[$urandom_range(recent_keys.size() - 1)];
		end else if (pick < 50) begin
			return 64'($urandom_range(1, 20));
		end else if (pick < 70) begin
			return {32'd0, $urandom};
		end
		return {$urandom, $urandom};
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.command    = ($urandom_range(99) < 40) ? CMD_READ : CMD_INSERT;
		r.key        = random_key();
		r.id_high    = ($urandom_range(19) == 0) ? '1 : {$urandom, $urandom};
		r.id_low     = ($urandom_range(19) == 0) ? '1 : {$urandom, $urandom};
		r.read_index = 6'($urandom_range(63));
		return r;
	endfunction

	task automatic send_item(input req_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		if (item.command == CMD_READ) begin
			n_read++;
		end else if (item.key == 64'd0) begin
			n_zero++;
		end else begin
			n_insert++;
			recent_keys.push_back(item.key);
			if (recent_keys.size() > 8) begin
				void'(recent_keys.pop_front());
			end
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (rsp_backlog != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_req(CMD_READ, '0, '0, '0, 6'd0));
		send_item(make_req(CMD_READ, '1, '1, '1, 6'd63));
		send_item(make_req(CMD_INSERT, '0, '1, '1, 6'd63));
		send_item(make_req(CMD_INSERT, '1, '1, '1, 6'd0));
		send_item(make_req(CMD_INSERT, 64'd1, '0, '0, 6'd0));
		send_item(make_req(CMD_INSERT, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			6'd5));
		send_item(make_req(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 6'd0));
		send_item(make_req(CMD_INSERT, 64'd1, 64'd7, 64'd9, 6'd0));
		send_item(make_req(CMD_INSERT, 64'd2, 64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555, 6'd0));
		send_item(make_req(CMD_INSERT, '0, 64'd3, 64'd4, 6'd63));
		for (int i = 0; i < 7; i++) begin
			send_item(make_req(CMD_READ, '0, '0, '0, 6'(i)));
		end
		send_item(make_req(CMD_READ, 64'd5, '1, '1, 6'd63));
		send_item(make_req(CMD_INSERT, {{63{1'b1}}, 1'b0}, '1, '0, 6'd0));
		send_item(make_req(CMD_READ, '1, '0, '1, 6'd1));

		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send_item(random_req());
		end
		wait_drained();

		tx_idle_pct = 49;
		rx_idle_pct <= 11;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send_item(random_req());
		end

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send_item(random_req());
		end
		wait_drained();
		repeat (100) @(posedge clk);

		$display("Covered %0d inserts, %0d zero-key inserts and %0d reads in three stall mixes,",
			n_insert, n_zero, n_read);
		$display("from an empty table through ties, evictions and drops on a full one.");
		if (fail_count == 0 && rsp_backlog == 0) begin
			$display("top_n_largest_tracker: match");
		end else begin
			$display("top_n_largest_tracker: mismatch");
		end
		$finish;
	end

endmodule
